// File: rtl/core/deficit_round_robin_scheduler_macros.svh
// Assertion macros used by the checker file of the scheduler.
`ifndef DEFICIT_ROUND_ROBIN_SCHEDULER_MACROS_SVH
`define DEFICIT_ROUND_ROBIN_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DRR_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("drr: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DRR_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("drr: assertion failed");

`endif

// File: rtl/core/drr_pkg.sv
`default_nettype none
package drr_pkg;

  localparam int NUM_CLASSES_DEF  = 4;
  localparam int QUEUE_DEPTH_DEF  = 64;
  localparam int SIZE_W           = 16;
  localparam int DEFICIT_W        = 17;
  localparam int ACTIVE_W         = 3;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 16;
  localparam int CLASS_W          = 2;
  localparam int NUM_QUANTUM_REGS = 4;
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET  = 3'd4;
  localparam logic [SIZE_W-1:0]   QUANTUM_RESET = 16'd1500;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE   = 3'd0,
    CFG_QUANTUM0 = 3'd1,
    CFG_QUANTUM1 = 3'd2,
    CFG_QUANTUM2 = 3'd3,
    CFG_QUANTUM3 = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    MODE_ENQ = 1'b0,
    MODE_DEQ = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_DROP  = 2'd1,
    ST_DEQ   = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ,
    S_SCAN,
    S_HEAD,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic                 fits;
    logic [DEFICIT_W-1:0] diff;
    logic [DEFICIT_W-1:0] sum;
  } alu_res_t;

endpackage
`default_nettype wire

// File: rtl/core/drr_if.sv
`default_nettype none
interface drr_in_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [drr_pkg::CLASS_W-1:0]   class_index;
  logic [drr_pkg::SIZE_W-1:0]    packet_size;
  modport source (output valid, output mode, output class_index, output packet_size,
                  input ready);
  modport sink   (input valid, input mode, input class_index, input packet_size,
                  output ready);
endinterface

interface drr_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [drr_pkg::CLASS_W-1:0]   served_class;
  logic [drr_pkg::SIZE_W-1:0]    served_size;
  modport source (output valid, output status, output served_class, output served_size,
                  input ready);
  modport sink   (input valid, input status, input served_class, input served_size,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/core/deficit_round_robin_scheduler.sv
// Deficit round robin scheduler over NUM_CLASSES classes with a size FIFO of
// QUEUE_DEPTH entries per class, held in one shared memory. Each transaction on
// the input is an enqueue or a dequeue request and yields exactly one result
// transaction. An enqueue passes through S_ENQ and S_DONE, and its result is
// loaded into the output register in the same cycle as the input becomes ready
// again. A dequeue is handled by a sequencer that visits one class at a time
// from the round pointer: an empty class is passed over in S_SCAN, while a
// non-empty class has its head size read from the single read port in S_SCAN
// and checked in S_HEAD, where the shared credit unit compares, subtracts or
// adds the quantum; S_DONE loads the output once the output register is free.
// The scan may circle several rounds before a head fits. The input is not
// ready while an item is in progress; a finished result may wait in the output
// register while the next transaction is taken. No clearing pass follows
// reset.
`default_nettype none
module deficit_round_robin_scheduler #(
  parameter int NUM_CLASSES = drr_pkg::NUM_CLASSES_DEF,
  parameter int QUEUE_DEPTH = drr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  drr_in_if.sink                               in_ch,
  drr_out_if.source                            out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [drr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [drr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  logic [drr_pkg::ACTIVE_W-1:0] active_r;
  logic [drr_pkg::SIZE_W-1:0]   quantum_r [NUM_CLASSES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= drr_pkg::ACTIVE_RESET;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        quantum_r[i] <= drr_pkg::QUANTUM_RESET;
      end
    end else if (cfg_we) begin
      if (cfg_index == drr_pkg::CFG_ACTIVE) begin
        active_r <= cfg_wdata[drr_pkg::ACTIVE_W-1:0];
      end
      // Quantum registers beyond the class count are accepted and ignored.
      for (int i = 0; i < NUM_CLASSES; i++) begin
        if ((i < drr_pkg::NUM_QUANTUM_REGS) &&
            (cfg_index == drr_pkg::CFG_IDX_W'(int'(drr_pkg::CFG_QUANTUM0) + i))) begin
          quantum_r[i] <= cfg_wdata[drr_pkg::SIZE_W-1:0];
        end
      end
    end
  end

  drr_seq #(
    .NUM_CLASSES (NUM_CLASSES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .active_classes (active_r),
    .quantum        (quantum_r)
  );

endmodule
`default_nettype wire

// File: rtl/core/drr_size_mem.sv
`default_nettype none
module drr_size_mem #(
  parameter int AW    = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [AW-1:0]               waddr,
  input  wire logic [drr_pkg::SIZE_W-1:0]  wdata,
  input  wire logic [AW-1:0]               raddr,
  output      logic [drr_pkg::SIZE_W-1:0]  rdata_r
);

  logic [drr_pkg::SIZE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/core/drr_credit_alu.sv
`default_nettype none
module drr_credit_alu (
  input  wire logic [drr_pkg::DEFICIT_W-1:0] deficit,
  input  wire logic [drr_pkg::SIZE_W-1:0]    head_size,
  input  wire logic [drr_pkg::SIZE_W-1:0]    quantum,
  output      drr_pkg::alu_res_t             res
);

  logic [drr_pkg::DEFICIT_W-1:0] head_ext;
  logic [drr_pkg::DEFICIT_W-1:0] q_ext;

  always_comb begin
    head_ext = {1'b0, head_size};
    // A zero quantum counts as one byte so that a scan always ends.
    q_ext    = (quantum == '0) ? drr_pkg::DEFICIT_W'(1) : {1'b0, quantum};
    res.fits = (head_ext <= deficit);
    res.diff = deficit - head_ext;
    res.sum  = deficit + q_ext;
  end

endmodule
`default_nettype wire

// File: rtl/core/drr_seq.sv
`default_nettype none
module drr_seq #(
  parameter int NUM_CLASSES = drr_pkg::NUM_CLASSES_DEF,
  parameter int QUEUE_DEPTH = drr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  drr_in_if.sink                             in_ch,
  drr_out_if.source                          out_ch,
  input  wire logic [drr_pkg::ACTIVE_W-1:0]  active_classes,
  input  wire logic [drr_pkg::SIZE_W-1:0]    quantum [NUM_CLASSES]
);

  localparam int CW   = $clog2(NUM_CLASSES);
  localparam int SW   = $clog2(QUEUE_DEPTH);
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
  localparam int NW   = $clog2(NUM_CLASSES + 1);
  localparam int LW   = (NW > drr_pkg::ACTIVE_W) ? NW : drr_pkg::ACTIVE_W;
  localparam int AW   = CW + SW;
  localparam int MEMD = NUM_CLASSES * (2 ** SW);
  localparam int DW   = drr_pkg::DEFICIT_W;
  localparam int ZW   = drr_pkg::SIZE_W;
  localparam int KW   = drr_pkg::CLASS_W;

  drr_pkg::seq_state_t state_r, state_nxt;
  logic [KW-1:0] cls_r, cls_nxt;
  logic [ZW-1:0] size_r, size_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic          any_r, any_nxt;
  logic [DW-1:0]   deficit_r [NUM_CLASSES];
  logic [DW-1:0]   deficit_nxt [NUM_CLASSES];
  logic [CNTW-1:0] count_r [NUM_CLASSES];
  logic [CNTW-1:0] count_nxt [NUM_CLASSES];
  logic [SW-1:0]   head_r [NUM_CLASSES];
  logic [SW-1:0]   head_nxt [NUM_CLASSES];
  logic [SW-1:0]   tail_r [NUM_CLASSES];
  logic [SW-1:0]   tail_nxt [NUM_CLASSES];

  drr_pkg::status_t res_status_r, res_status_nxt;
  logic [KW-1:0]    res_class_r, res_class_nxt;
  logic [ZW-1:0]    res_size_r, res_size_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [KW-1:0] out_class_r, out_class_nxt;
  logic [ZW-1:0] out_size_r, out_size_nxt;

  logic [LW-1:0]   live_n;
  logic [LW-1:0]   act_ext;
  logic [CW+KW-1:0] cls_ext;
  logic [CW-1:0]   cls_sel;
  logic [CW+KW-1:0] ptr_ext;
  logic [KW-1:0]   ptr_cls;
  logic [CW-1:0]   ptr_adv;
  logic            pass_end;
  logic [SW-1:0]   tail_inc;
  logic [SW-1:0]   head_inc;
  logic            out_free;
  logic            in_acc;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [AW-1:0]   mem_raddr;
  logic [ZW-1:0]   mem_rdata;
  drr_pkg::alu_res_t alu_res;

  drr_size_mem #(.AW(AW), .DEPTH(MEMD)) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (size_r),
    .raddr   (mem_raddr),
    .rdata_r (mem_rdata)
  );

  drr_credit_alu u_alu (
    .deficit   (deficit_r[ptr_r]),
    .head_size (mem_rdata),
    .quantum   (quantum[ptr_r]),
    .res       (alu_res)
  );

  // Live class count: zero acts as one, and the count is capped at the class count.
  always_comb begin
    act_ext = LW'(active_classes);
    if (act_ext == '0) begin
      live_n = LW'(1);
    end else if (act_ext > LW'(NUM_CLASSES)) begin
      live_n = LW'(NUM_CLASSES);
    end else begin
      live_n = act_ext;
    end
  end

  assign cls_ext  = {{CW{1'b0}}, cls_r};
  assign cls_sel  = cls_ext[CW-1:0];
  assign ptr_ext  = {{KW{1'b0}}, ptr_r};
  assign ptr_cls  = ptr_ext[KW-1:0];
  assign ptr_adv  = ((LW'(ptr_r) + LW'(1)) >= live_n) ? '0 : ptr_r + CW'(1);
  assign pass_end = ((LW'(k_r) + LW'(1)) == live_n);
  assign tail_inc = (tail_r[cls_sel] == SW'(QUEUE_DEPTH - 1)) ? '0 : tail_r[cls_sel] + SW'(1);
  assign head_inc = (head_r[ptr_r] == SW'(QUEUE_DEPTH - 1)) ? '0 : head_r[ptr_r] + SW'(1);
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_acc   = in_ch.valid && in_ch.ready;

  assign mem_waddr = {cls_sel, tail_r[cls_sel]};
  assign mem_raddr = {ptr_r, head_r[ptr_r]};

  assign in_ch.ready         = (state_r == drr_pkg::S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.served_class = out_class_r;
  assign out_ch.served_size  = out_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= drr_pkg::S_IDLE;
      ptr_r       <= '0;
      k_r         <= '0;
      any_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        deficit_r[i] <= '0;
        count_r[i]   <= '0;
        head_r[i]    <= '0;
        tail_r[i]    <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      k_r         <= k_nxt;
      any_r       <= any_nxt;
      out_valid_r <= out_valid_nxt;
      deficit_r   <= deficit_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cls_r        <= cls_nxt;
    size_r       <= size_nxt;
    res_status_r <= res_status_nxt;
    res_class_r  <= res_class_nxt;
    res_size_r   <= res_size_nxt;
    out_status_r <= out_status_nxt;
    out_class_r  <= out_class_nxt;
    out_size_r   <= out_size_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    cls_nxt        = cls_r;
    size_nxt       = size_r;
    ptr_nxt        = ptr_r;
    k_nxt          = k_r;
    any_nxt        = any_r;
    deficit_nxt    = deficit_r;
    count_nxt      = count_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    res_status_nxt = res_status_r;
    res_class_nxt  = res_class_r;
    res_size_nxt   = res_size_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_class_nxt  = out_class_r;
    out_size_nxt   = out_size_r;
    mem_we         = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      drr_pkg::S_IDLE: begin
        if (in_acc) begin
          cls_nxt  = in_ch.class_index;
          size_nxt = in_ch.packet_size;
          if (in_ch.mode == drr_pkg::MODE_DEQ) begin
            // A pointer left beyond a shrunken class set restarts at class 0.
            if (LW'(ptr_r) >= live_n) begin
              ptr_nxt = '0;
            end
            k_nxt     = '0;
            any_nxt   = 1'b0;
            state_nxt = drr_pkg::S_SCAN;
          end else begin
            state_nxt = drr_pkg::S_ENQ;
          end
        end
      end
      drr_pkg::S_ENQ: begin
        res_class_nxt = cls_r;
        res_size_nxt  = '0;
        if ((LW'(cls_r) >= live_n) || (count_r[cls_sel] == CNTW'(QUEUE_DEPTH))) begin
          res_status_nxt = drr_pkg::ST_DROP;
        end else begin
          mem_we             = 1'b1;
          tail_nxt[cls_sel]  = tail_inc;
          count_nxt[cls_sel] = count_r[cls_sel] + CNTW'(1);
          res_status_nxt     = drr_pkg::ST_ENQ;
        end
        state_nxt = drr_pkg::S_DONE;
      end
      drr_pkg::S_SCAN: begin
        if (count_r[ptr_r] == '0) begin
          deficit_nxt[ptr_r] = '0;
          ptr_nxt            = ptr_adv;
          if (pass_end) begin
            k_nxt   = '0;
            any_nxt = 1'b0;
            if (!any_r) begin
              res_status_nxt = drr_pkg::ST_EMPTY;
              res_class_nxt  = '0;
              res_size_nxt   = '0;
              state_nxt      = drr_pkg::S_DONE;
            end
          end else begin
            k_nxt = k_r + CW'(1);
          end
        end else begin
          // The head size is read this cycle and checked in the next.
          state_nxt = drr_pkg::S_HEAD;
        end
      end
      drr_pkg::S_HEAD: begin
        if (alu_res.fits) begin
          deficit_nxt[ptr_r] = alu_res.diff;
          head_nxt[ptr_r]    = head_inc;
          count_nxt[ptr_r]   = count_r[ptr_r] - CNTW'(1);
          res_status_nxt     = drr_pkg::ST_DEQ;
          res_class_nxt      = ptr_cls;
          res_size_nxt       = mem_rdata;
          state_nxt          = drr_pkg::S_DONE;
        end else begin
          deficit_nxt[ptr_r] = alu_res.sum;
          ptr_nxt            = ptr_adv;
          if (pass_end) begin
            k_nxt   = '0;
            any_nxt = 1'b0;
          end else begin
            k_nxt   = k_r + CW'(1);
            any_nxt = 1'b1;
          end
          state_nxt = drr_pkg::S_SCAN;
        end
      end
      drr_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_class_nxt  = res_class_r;
          out_size_nxt   = res_size_r;
          state_nxt      = drr_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = drr_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/drr_checker.sv
`default_nettype none
`include "deficit_round_robin_scheduler_macros.svh"
module drr_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [1:0]                    status,
  input wire logic [drr_pkg::CLASS_W-1:0]   served_class,
  input wire logic [drr_pkg::SIZE_W-1:0]    served_size
);

  // Only one transaction is in progress at a time.
  `DRR_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  // Only a dequeued result carries a size.
  `DRR_ASSERT_IMPL(a_size_only_on_deq, clk, rst_n, out_valid && (status != drr_pkg::ST_DEQ), served_size == '0)
  // The all-empty result names class zero.
  `DRR_ASSERT_IMPL(a_empty_class_zero, clk, rst_n, out_valid && (status == drr_pkg::ST_EMPTY), served_class == '0)
  // A stalled result holds.
  `DRR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(served_size))

endmodule

bind deficit_round_robin_scheduler drr_checker u_drr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .status       (out_ch.status),
  .served_class (out_ch.served_class),
  .served_size  (out_ch.served_size)
);
`default_nettype wire

// File: bench/tb_deficit_round_robin_scheduler.sv
`timescale 1ns / 100ps

typedef struct {
  drr_pkg::status_t status;
  logic [1:0]       cls;
  logic [15:0]      size;
} drr_outcome_t;

// Mirror of the scheduler: per-class size FIFOs, credits, the round pointer
// and the outcomes that the block still owes.
class drr_dispatch_board;
  logic [drr_pkg::ACTIVE_W-1:0]  active_reg;
  logic [drr_pkg::SIZE_W-1:0]    quantum_reg [drr_pkg::NUM_CLASSES_DEF];
  logic [drr_pkg::DEFICIT_W-1:0] credit [drr_pkg::NUM_CLASSES_DEF];
  logic [1:0]                    turn;
  logic [drr_pkg::SIZE_W-1:0]    slot [drr_pkg::NUM_CLASSES_DEF][drr_pkg::QUEUE_DEPTH_DEF];
  int                            fill [drr_pkg::NUM_CLASSES_DEF];
  int                            rd_pos [drr_pkg::NUM_CLASSES_DEF];
  int                            wr_pos [drr_pkg::NUM_CLASSES_DEF];
  drr_outcome_t                  pending_outcomes [$];

  function new();
    active_reg = drr_pkg::ACTIVE_RESET;
    turn = '0;
    for (int i = 0; i < drr_pkg::NUM_CLASSES_DEF; i++) begin
      quantum_reg[i] = drr_pkg::QUANTUM_RESET;
      credit[i] = '0;
      fill[i] = 0;
      rd_pos[i] = 0;
      wr_pos[i] = 0;
    end
  endfunction

  function void write_reg(drr_pkg::cfg_reg_t idx, logic [drr_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      drr_pkg::CFG_ACTIVE:   active_reg = val[drr_pkg::ACTIVE_W-1:0];
      drr_pkg::CFG_QUANTUM0: quantum_reg[0] = val;
      drr_pkg::CFG_QUANTUM1: quantum_reg[1] = val;
      drr_pkg::CFG_QUANTUM2: quantum_reg[2] = val;
      drr_pkg::CFG_QUANTUM3: quantum_reg[3] = val;
      default: ;
    endcase
  endfunction

  // Out-of-range active counts are clamped into 1..NUM_CLASSES.
  function int live_classes();
    int n;
    n = active_reg;
    if (n == 0) n = 1;
    if (n > drr_pkg::NUM_CLASSES_DEF) n = drr_pkg::NUM_CLASSES_DEF;
    return n;
  endfunction

  function int live_backlog();
    int total;
    total = 0;
    for (int c = 0; c < live_classes(); c++) total += fill[c];
    return total;
  endfunction

  function int outstanding();
    return pending_outcomes.size();
  endfunction

  function drr_outcome_t serve_next();
    drr_outcome_t o;
    int n;
    int c;
    int head;
    int gain;
    bit any;
    o.status = drr_pkg::ST_EMPTY;
    o.cls = '0;
    o.size = '0;
    n = live_classes();
    if (turn >= n) turn = '0;
    while (1) begin
      any = 0;
      for (int k = 0; k < n; k++) begin
        c = turn;
        if (fill[c] == 0) begin
          credit[c] = '0;
          turn = (c + 1 >= n) ? 0 : c + 1;
          continue;
        end
        any = 1;
        head = slot[c][rd_pos[c]];
        if (head <= credit[c]) begin
          credit[c] = credit[c] - head;
          rd_pos[c] = (rd_pos[c] + 1) % drr_pkg::QUEUE_DEPTH_DEF;
          fill[c]--;
          o.status = drr_pkg::ST_DEQ;
          o.cls = c;
          o.size = head;
          return o;
        end
        gain = (quantum_reg[c] == 0) ? 1 : quantum_reg[c];
        credit[c] = credit[c] + gain;
        turn = (c + 1 >= n) ? 0 : c + 1;
      end
      if (!any) return o;
    end
  endfunction

  function void note_request(logic mode, logic [1:0] cls, logic [15:0] size);
    drr_outcome_t o;
    if (mode == drr_pkg::MODE_ENQ) begin
      o.cls = cls;
      o.size = '0;
      if (cls >= live_classes() || fill[cls] >= drr_pkg::QUEUE_DEPTH_DEF) begin
        o.status = drr_pkg::ST_DROP;
      end else begin
        o.status = drr_pkg::ST_ENQ;
        slot[cls][wr_pos[cls]] = size;
        wr_pos[cls] = (wr_pos[cls] + 1) % drr_pkg::QUEUE_DEPTH_DEF;
        fill[cls]++;
      end
    end else begin
      o = serve_next();
    end
    pending_outcomes.push_back(o);
  endfunction

  function bit check_outcome(logic [1:0] st, logic [1:0] cls, logic [15:0] size,
                             output string msg);
    drr_outcome_t e;
    msg = "";
    if (pending_outcomes.size() == 0) begin
      msg = $sformatf("result with nothing pending: status %0d class %0d size %0d",
                      st, cls, size);
      return 0;
    end
    e = pending_outcomes.pop_front();
    if (st !== e.status || cls !== e.cls || size !== e.size) begin
      msg = $sformatf("got status %0d class %0d size %0d, wanted %0d %0d %0d",
                      st, cls, size, e.status, e.cls, e.size);
      return 0;
    end
    return 1;
  endfunction
endclass

module tb_deficit_round_robin_scheduler;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 16;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [drr_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [drr_pkg::CFG_DATA_W-1:0] cfg_wdata;
  int                             errors;
  int                             send_calm;
  int                             recv_calm;
  drr_dispatch_board              board;

  drr_in_if  in_ch ();
  drr_out_if out_ch ();

  deficit_round_robin_scheduler u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  task automatic report_mismatch(input string msg);
    errors++;
    $display("ERROR: %s", msg);
  endtask

  // Mostly short gaps, a few long ones, and now and then a calm stretch.
  function automatic int pick_delay(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(input logic mode, input logic [1:0] cls, input logic [15:0] size);
    int gap;
    gap = pick_delay(send_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= mode;
    in_ch.class_index <= cls;
    in_ch.packet_size <= size;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    board.note_request(mode, cls, size);
  endtask

  task automatic wait_settled();
    in_ch.valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] act, input logic [15:0] q0,
                            input logic [15:0] q1, input logic [15:0] q2,
                            input logic [15:0] q3);
    drr_pkg::cfg_reg_t idx [5];
    logic [15:0]       val [5];
    idx = '{drr_pkg::CFG_ACTIVE, drr_pkg::CFG_QUANTUM0, drr_pkg::CFG_QUANTUM1,
            drr_pkg::CFG_QUANTUM2, drr_pkg::CFG_QUANTUM3};
    val = '{act, q0, q1, q2, q3};
    wait_settled();
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
      board.write_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // Sizes stay within a few rounds of the smallest quantum so that no
  // dequeue circles for long.
  task automatic send_random(input int count, input int enq_pct, input int size_cap,
                             input int hot_pct);
    logic        mode;
    logic [1:0]  cls;
    logic [15:0] size;
    int          r;
    for (int i = 0; i < count; i++) begin
      mode = ($urandom_range(0, 99) >= enq_pct) ? drr_pkg::MODE_DEQ : drr_pkg::MODE_ENQ;
      cls = ($urandom_range(0, 99) < hot_pct) ? 2'd0 : 2'($urandom_range(0, 3));
      r = $urandom_range(0, 19);
      if (mode == drr_pkg::MODE_DEQ) size = 16'($urandom());
      else if (r == 0) size = '0;
      else if (r == 1) size = 16'(size_cap);
      else size = 16'($urandom_range(0, size_cap));
      send_item(mode, cls, size);
    end
  endtask

  // Dequeue until every live class is empty, then once more for all empty.
  task automatic drain_backlog();
    while (board.live_backlog() > 0) begin
      send_item(drr_pkg::MODE_DEQ, 2'($urandom()), 16'($urandom()));
    end
    send_item(drr_pkg::MODE_DEQ, 2'($urandom()), 16'($urandom()));
  endtask

  initial begin : result_sink
    string msg;
    int    stall;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      stall = pick_delay(recv_calm);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      if (!board.check_outcome(out_ch.status, out_ch.served_class, out_ch.served_size,
                               msg))
        report_mismatch(msg);
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    clk               = 1'b0;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.mode        = drr_pkg::MODE_ENQ;
    in_ch.class_index = '0;
    in_ch.packet_size = '0;
    out_ch.ready      = 1'b0;
    errors            = 0;
    send_calm         = 0;
    recv_calm         = 0;
    board             = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty scheduler, size extremes, fits and misses, drops.
    send_item(drr_pkg::MODE_DEQ, 2'd2, 16'hFFFF);
    send_item(drr_pkg::MODE_ENQ, 2'd0, 16'd0);
    send_item(drr_pkg::MODE_ENQ, 2'd1, 16'hFFFF);
    send_item(drr_pkg::MODE_ENQ, 2'd2, 16'd1);
    send_item(drr_pkg::MODE_ENQ, 2'd3, 16'd1500);
    send_item(drr_pkg::MODE_ENQ, 2'd0, 16'd1500);
    send_item(drr_pkg::MODE_ENQ, 2'd0, 16'd1501);
    repeat (7) send_item(drr_pkg::MODE_DEQ, 2'd0, 16'd0);
    set_config(16'd2, 16'd1500, 16'd1500, 16'd1500, 16'd1500);
    send_item(drr_pkg::MODE_ENQ, 2'd3, 16'd10);
    send_item(drr_pkg::MODE_ENQ, 2'd2, 16'd10);
    send_item(drr_pkg::MODE_ENQ, 2'd1, 16'd3000);
    send_item(drr_pkg::MODE_DEQ, 2'd3, 16'hFFFF);
    send_item(drr_pkg::MODE_DEQ, 2'd1, 16'd0);

    set_config(16'd4, 16'd1500, 16'd1500, 16'd1500, 16'd1500);
    send_random(55, 55, 6000, 0);
    drain_backlog();

    // Zero and unit quanta with tiny packets.
    set_config(16'd3, 16'd0, 16'd1, 16'd2, 16'hFFFF);
    send_random(60, 55, 4, 0);
    drain_backlog();

    // One class flooded until its FIFO overflows.
    set_config(16'd1, 16'd3, 16'd3, 16'd3, 16'd3);
    send_random(110, 92, 12, 85);
    drain_backlog();

    // Large packets, then the active set shrinks and strands the other
    // classes before growing back past the class count.
    set_config(16'd4, 16'hFFFF, 16'hFFFF, 16'd20000, 16'd40000);
    send_random(50, 65, 65535, 0);
    set_config(16'd0, 16'hFFFF, 16'hFFFF, 16'd20000, 16'd40000);
    send_random(40, 50, 65535, 0);
    set_config(16'd7, 16'd30000, 16'd16384, 16'd50000, 16'hFFFF);
    send_random(50, 50, 65535, 0);
    drain_backlog();

    set_config(16'd2, 16'd100, 16'd250, 16'd1, 16'd1);
    send_random(50, 60, 400, 0);
    drain_backlog();

    set_config(16'd5, 16'd7, 16'd700, 16'd70, 16'd7000);
    send_random(50, 55, 28, 0);
    drain_backlog();

    wait_settled();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+rtl/core
rtl/core/drr_pkg.sv
rtl/core/drr_if.sv
rtl/core/drr_size_mem.sv
rtl/core/drr_credit_alu.sv
rtl/core/drr_seq.sv
rtl/core/deficit_round_robin_scheduler.sv
rtl/core/drr_checker.sv
bench/tb_deficit_round_robin_scheduler.sv
